// ===== src/spi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the divider step for the segment pair intersection unit.
// No dependencies.
package spi_pkg;

  localparam int CW = 32;          // coordinate width, signed Q16.16
  localparam int RW = 2 * CW + 3;  // cross product / remainder width

  localparam logic MODE_FULL   = 1'b0;
  localparam logic MODE_STRIPE = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic signed [CW-1:0] first_org_x;
    logic signed [CW-1:0] first_org_y;
    logic signed [CW-1:0] first_delta_x;
    logic signed [CW-1:0] first_delta_y;
    logic signed [CW-1:0] second_org_x;
    logic signed [CW-1:0] second_org_y;
    logic signed [CW-1:0] second_delta_x;
    logic signed [CW-1:0] second_delta_y;
    logic signed [CW-1:0] stripe_begin;
    logic signed [CW-1:0] stripe_end;
  } spi_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
  } spi_out_t;

  // One item on its way through the divider
  typedef struct packed {
    logic                 ok;
    logic                 mode;
    logic signed [CW-1:0] org_x;
    logic signed [CW-1:0] org_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [CW-1:0]        mag_x;
    logic [CW-1:0]        mag_y;
    logic [RW-1:0]        num;
    logic [RW-1:0]        den;
    logic [RW-1:0]        rem_x;
    logic [RW-1:0]        rem_y;
    logic [CW-1:0]        quo_x;
    logic [CW-1:0]        quo_y;
    logic signed [CW-1:0] stripe_begin;
    logic signed [CW-1:0] stripe_end;
  } div_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [CW-1:0] quo;
  } step_t;

  // One bit of floor(mag * num / den), remainder kept below den
  function automatic step_t div_step(input logic [RW-1:0] r, input logic [CW-1:0] q,
                                     input logic b, input logic [RW-1:0] n,
                                     input logic [RW-1:0] d);
    logic [RW-1:0] rr;
    logic [CW-1:0] qq;
    step_t         s;
    rr = {r[RW-2:0], 1'b0};
    qq = {q[CW-2:0], 1'b0};
    if (rr >= d) begin
      rr = rr - d;
      qq = qq + CW'(1);
    end
    if (b) begin
      rr = rr + n;
      if (rr >= d) begin
        rr = rr - d;
        qq = qq + CW'(1);
      end
    end
    s.rem = rr;
    s.quo = qq;
    return s;
  endfunction

endpackage

// ===== src/spi_cross.sv =====
`timescale 1ns / 1ps
// Front end: differences, six products, cross products and hit conditions (3 stages).
// Depends on spi_pkg.
module spi_cross import spi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_vld,
  input  spi_in_t in_item,
  output logic    out_vld,
  output div_t    out_item
);

  // stage A
  logic signed [CW:0]     dx, dy, e1, e2, b1, b2;
  logic signed [2*CW-1:0] pa_nxt, pb_nxt;
  logic signed [2*CW:0]   pc_nxt, pd_nxt, pe_nxt, pf_nxt;

  logic                   a_vld_r;
  spi_in_t                a_item_r;
  logic                   a_span_r;
  logic signed [2*CW-1:0] pa_r, pb_r;
  logic signed [2*CW:0]   pc_r, pd_r, pe_r, pf_r;

  always_comb begin
    dx = (CW+1)'(in_item.second_org_x) - (CW+1)'(in_item.first_org_x);
    dy = (CW+1)'(in_item.second_org_y) - (CW+1)'(in_item.first_org_y);
    e1 = (CW+1)'(in_item.first_org_x) + (CW+1)'(in_item.first_delta_x);
    e2 = (CW+1)'(in_item.second_org_x) + (CW+1)'(in_item.second_delta_x);
    b1 = (in_item.first_org_x > in_item.second_org_x) ? (CW+1)'(in_item.first_org_x)
                                                       : (CW+1)'(in_item.second_org_x);
    b2 = (e1 < e2) ? e1 : e2;
    pa_nxt = (2*CW)'(in_item.first_delta_x) * (2*CW)'(in_item.second_delta_y);
    pb_nxt = (2*CW)'(in_item.first_delta_y) * (2*CW)'(in_item.second_delta_x);
    pc_nxt = (2*CW+1)'(in_item.first_delta_x) * (2*CW+1)'(dy);
    pd_nxt = (2*CW+1)'(in_item.first_delta_y) * (2*CW+1)'(dx);
    pe_nxt = (2*CW+1)'(dx) * (2*CW+1)'(in_item.second_delta_y);
    pf_nxt = (2*CW+1)'(dy) * (2*CW+1)'(in_item.second_delta_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
    if (en) begin
      a_item_r <= in_item;
      a_span_r <= (b1 < b2);
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      pc_r     <= pc_nxt;
      pd_r     <= pd_nxt;
      pe_r     <= pe_nxt;
      pf_r     <= pf_nxt;
    end
  end

  // stage B: cross products
  logic                 b_vld_r;
  spi_in_t              b_item_r;
  logic                 b_span_r;
  logic signed [RW-1:0] prod_r, m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
    if (en) begin
      b_item_r <= a_item_r;
      b_span_r <= a_span_r;
      prod_r   <= RW'(pa_r) - RW'(pb_r);
      m1_r     <= RW'(pc_r) - RW'(pd_r);
      m2_r     <= RW'(pe_r) - RW'(pf_r);
    end
  end

  // stage C: straddle tests, magnitudes, divider entry
  logic signed [RW-1:0] s2_sum, s1_dif;
  logic                 straddle1, straddle2, nz;
  div_t                 c_nxt;

  always_comb begin
    s2_sum    = m1_r + prod_r;
    s1_dif    = m2_r - prod_r;
    straddle2 = (m1_r > 0) != (s2_sum > 0);
    straddle1 = (m2_r > 0) != (s1_dif > 0);
    nz        = (prod_r != '0);
    c_nxt              = '0;
    c_nxt.mode         = b_item_r.mode;
    c_nxt.den          = prod_r[RW-1] ? RW'(-prod_r) : RW'(prod_r);
    c_nxt.stripe_begin = b_item_r.stripe_begin;
    c_nxt.stripe_end   = b_item_r.stripe_end;
    if (b_item_r.mode == MODE_STRIPE) begin
      c_nxt.ok    = straddle2 && nz;
      c_nxt.num   = m1_r[RW-1] ? RW'(-m1_r) : RW'(m1_r);
      c_nxt.org_x = b_item_r.second_org_x;
      c_nxt.org_y = b_item_r.second_org_y;
      c_nxt.neg_x = b_item_r.second_delta_x[CW-1];
      c_nxt.neg_y = b_item_r.second_delta_y[CW-1];
      c_nxt.mag_x = b_item_r.second_delta_x[CW-1] ? CW'(-b_item_r.second_delta_x)
                                                   : CW'(b_item_r.second_delta_x);
      c_nxt.mag_y = b_item_r.second_delta_y[CW-1] ? CW'(-b_item_r.second_delta_y)
                                                   : CW'(b_item_r.second_delta_y);
    end else begin
      c_nxt.ok    = b_span_r && straddle2 && straddle1 && nz;
      c_nxt.num   = m2_r[RW-1] ? RW'(-m2_r) : RW'(m2_r);
      c_nxt.org_x = b_item_r.first_org_x;
      c_nxt.org_y = b_item_r.first_org_y;
      c_nxt.neg_x = b_item_r.first_delta_x[CW-1];
      c_nxt.neg_y = b_item_r.first_delta_y[CW-1];
      c_nxt.mag_x = b_item_r.first_delta_x[CW-1] ? CW'(-b_item_r.first_delta_x)
                                                  : CW'(b_item_r.first_delta_x);
      c_nxt.mag_y = b_item_r.first_delta_y[CW-1] ? CW'(-b_item_r.first_delta_y)
                                                  : CW'(b_item_r.first_delta_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= b_vld_r;
    end
    if (en) begin
      out_item <= c_nxt;
    end
  end

endmodule

// ===== src/spi_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, x and y lanes side by side.
// Depends on spi_pkg.
module spi_div import spi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  div_t in_item,
  output logic out_vld,
  output div_t out_item
);

  logic [CW-1:0] vld_r;
  div_t          stg_r [CW];

  genvar k;
  generate
    for (k = 0; k < CW; k++) begin : g_stage
      div_t  src;
      logic  src_vld;
      step_t sx, sy;
      div_t  stg_nxt;

      if (k == 0) begin : g_first
        assign src     = in_item;
        assign src_vld = in_vld;
      end else begin : g_next
        assign src     = stg_r[k-1];
        assign src_vld = vld_r[k-1];
      end

      always_comb begin
        sx = div_step(src.rem_x, src.quo_x, src.mag_x[CW-1-k], src.num, src.den);
        sy = div_step(src.rem_y, src.quo_y, src.mag_y[CW-1-k], src.num, src.den);
        stg_nxt       = src;
        stg_nxt.rem_x = sx.rem;
        stg_nxt.quo_x = sx.quo;
        stg_nxt.rem_y = sy.rem;
        stg_nxt.quo_y = sy.quo;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= src_vld;
        end
        if (en) begin
          stg_r[k] <= stg_nxt;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[CW-1];
  assign out_item = stg_r[CW-1];

endmodule

// ===== src/segment_pair_intersection_unit.sv =====
`timescale 1ns / 1ps
// Segment pair intersection unit: top level, final point assembly and output register.
// Depends on spi_pkg, spi_cross and spi_div.
//
// Usage
//   Input channel in_valid / in_stall / in_data carries one segment pair per beat.
//   Result channel out_valid / out_stall / out_data returns one result beat per
//   input beat, in order: hit flag and the saturated crossing point (zero on miss).
//   The pipeline holds three front-end stages for products and cross products,
//   one divider stage per quotient bit, and the output register. Throughput is
//   one pair per cycle while out_stall does not hold a result; the divider is
//   fully pipelined, so the bit-per-stage divider chain sets the latency.
//   The whole pipeline moves on a common enable; in_stall is raised only while a
//   finished result sits in the output register and out_stall holds it, so a
//   stall loses and repeats no beat. Bubbles are not squeezed out.
//   Reset (synchronous, rst_n low) clears every valid bit; payload registers
//   are not reset. The block holds no state between pairs.
module segment_pair_intersection_unit import spi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spi_out_t out_data
);

  logic en;
  logic acc;
  logic x_vld, d_vld;
  div_t x_item, d_item;

  // advance whenever the output register is free or being emptied
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign acc      = in_valid && en;

  spi_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (acc),
    .in_item  (in_data),
    .out_vld  (x_vld),
    .out_item (x_item)
  );

  spi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (x_vld),
    .in_item  (x_item),
    .out_vld  (d_vld),
    .out_item (d_item)
  );

  // final stage: signed offset onto the origin, stripe window, saturation
  localparam logic signed [CW+1:0] SAT_HI = (CW+2)'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [CW+1:0] SAT_LO = -SAT_HI - (CW+2)'(1);

  logic signed [CW+1:0] off_x, off_y, px, py;
  logic                 in_win, hit;
  spi_out_t             res_nxt;

  always_comb begin
    off_x  = d_item.neg_x ? -(CW+2)'({1'b0, d_item.quo_x}) : (CW+2)'({1'b0, d_item.quo_x});
    off_y  = d_item.neg_y ? -(CW+2)'({1'b0, d_item.quo_y}) : (CW+2)'({1'b0, d_item.quo_y});
    px     = (CW+2)'(d_item.org_x) + off_x;
    py     = (CW+2)'(d_item.org_y) + off_y;
    in_win = (px > (CW+2)'(d_item.stripe_begin)) && (px <= (CW+2)'(d_item.stripe_end));
    hit    = d_item.ok && ((d_item.mode == MODE_FULL) || in_win);
    res_nxt = '0;
    if (hit) begin
      res_nxt.hit     = 1'b1;
      res_nxt.point_x = (px > SAT_HI) ? CW'(SAT_HI) : (px < SAT_LO) ? CW'(SAT_LO) : CW'(px);
      res_nxt.point_y = (py > SAT_HI) ? CW'(SAT_HI) : (py < SAT_LO) ? CW'(SAT_LO) : CW'(py);
    end
  end

  logic     out_valid_r;
  spi_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld;
    end
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
